// File: rtl/asfc_pkg.sv
package asfc_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4
  } fmt_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SRC_FMT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DST_FMT = 1'b1;

  // fixed point used between scale and round stages: 25 fraction bits
  localparam int unsigned MagW = 57;
  localparam int unsigned FracW = 25;

  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_MIN   = 2'd1,
    K_MAX   = 2'd2,
    K_ROUND = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              neg;
    logic [MagW-1:0]   mag;   // |n| +/- 0.5, or float bits for float output
  } scl_t;

  // power of two between unit range and integer range
  function automatic logic [4:0] fmt_shift(fmt_e fmt);
    logic [4:0] k;
    case (fmt)
      FMT_U8:  k = 5'd7;
      FMT_S16: k = 5'd15;
      FMT_S24: k = 5'd23;
      FMT_S32: k = 5'd31;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/audio_sample_format_converter.sv
// Audio sample format converter.
// Command channel: a sample (sample_in_i, last_in_i) is taken at each clock
// edge where start is high and busy is low. busy stays low, so one sample
// can be issued every cycle with no gaps.
// Result channel: result_valid_o is high for exactly one cycle with
// sample_out_o and last_out_o; the receiver must take it in that cycle.
// Throughput is one sample per cycle. The path is four register stages:
// input, int-to-float, scale/clamp, round/format.
// Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_index_i 0 is
// the source format, 1 the destination format (3-bit codes: 0 u8 offset,
// 1 s16, 2 s24, 3 s32, 4 float). cfg_ready_o is always high. Write it only
// with no samples in flight.
// Reset clears the pipeline valid bits and sets both formats to s16.
module audio_sample_format_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    sample_in_i,
  input  logic                           last_in_i,
  output logic                           result_valid_o,
  output logic [31:0]                    sample_out_o,
  output logic                           last_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [2:0]                     cfg_data_i
);

  asfc_pkg::fmt_e src_fmt_q;
  asfc_pkg::fmt_e dst_fmt_q;

  logic           in_valid_q;
  logic [31:0]    in_sample_q;
  logic           in_last_q;
  logic           f1_valid_q;
  logic [31:0]    f1_bits_d;
  logic [31:0]    f1_bits_q;
  logic           f1_last_q;
  logic           s2_valid_q;
  asfc_pkg::scl_t s2_d;
  asfc_pkg::scl_t s2_q;
  logic           s2_last_q;
  logic           out_valid_q;
  logic [31:0]    out_sample_d;
  logic [31:0]    out_sample_q;
  logic           out_last_q;
  logic           accept;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= asfc_pkg::FMT_S16;
      dst_fmt_q <= asfc_pkg::FMT_S16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        asfc_pkg::CFG_SRC_FMT: src_fmt_q <= asfc_pkg::fmt_e'(cfg_data_i);
        asfc_pkg::CFG_DST_FMT: dst_fmt_q <= asfc_pkg::fmt_e'(cfg_data_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      f1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      f1_valid_q  <= in_valid_q;
      s2_valid_q  <= f1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_sample_q <= sample_in_i;
      in_last_q   <= last_in_i;
    end
    f1_bits_q    <= f1_bits_d;
    f1_last_q    <= in_last_q;
    s2_q         <= s2_d;
    s2_last_q    <= f1_last_q;
    out_sample_q <= out_sample_d;
    out_last_q   <= s2_last_q;
  end

  asfc_to_float u_to_float (
    .src_fmt_i (src_fmt_q),
    .raw_i     (in_sample_q),
    .fbits_o   (f1_bits_d)
  );

  asfc_scale u_scale (
    .dst_fmt_i (dst_fmt_q),
    .fbits_i   (f1_bits_q),
    .scl_o     (s2_d)
  );

  asfc_round u_round (
    .dst_fmt_i (dst_fmt_q),
    .scl_i     (s2_q),
    .sample_o  (out_sample_d)
  );

  assign result_valid_o = out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign last_out_o     = out_last_q;

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> result_valid_o)
    else $error("scaled sample did not reach the result register");

  a_u8_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dst_fmt_q == asfc_pkg::FMT_U8) |-> sample_out_o[31:8] == '0)
    else $error("u8 result has bits above the byte");

  a_bad_dst_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dst_fmt_q != asfc_pkg::FMT_U8 && dst_fmt_q != asfc_pkg::FMT_S16 &&
     dst_fmt_q != asfc_pkg::FMT_S24 && dst_fmt_q != asfc_pkg::FMT_S32 &&
     dst_fmt_q != asfc_pkg::FMT_F32) |-> sample_out_o == '0)
    else $error("unknown destination format gave a nonzero result");

endmodule

// File: rtl/asfc_to_float.sv
module asfc_to_float (
  input  asfc_pkg::fmt_e src_fmt_i,
  input  logic [31:0]    raw_i,
  output logic [31:0]    fbits_o
);

  logic [32:0] w;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [4:0]  k;
  logic [3:0]  lsb;
  logic [23:0] man0;
  logic [31:0] rem;
  logic [31:0] half;
  logic        inc;
  logic [24:0] man25;
  logic [23:0] man;
  logic [5:0]  pe;
  logic [7:0]  expo;
  logic        is_int;

  always_comb begin
    is_int = 1'b1;
    case (src_fmt_i)
      asfc_pkg::FMT_U8:  w = 33'({1'b0, raw_i[7:0]}) - 33'd128;
      asfc_pkg::FMT_S16: w = {{17{raw_i[15]}}, raw_i[15:0]};
      asfc_pkg::FMT_S24: w = {{9{raw_i[23]}}, raw_i[23:0]};
      asfc_pkg::FMT_S32: w = {raw_i[31], raw_i};
      default: begin
        w = '0;
        is_int = 1'b0;
      end
    endcase
    k = asfc_pkg::fmt_shift(src_fmt_i);
    mag = w[32] ? 32'(~w + 33'd1) : w[31:0];

    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end

    lsb = '0;
    man0 = '0;
    rem = '0;
    half = '0;
    inc = 1'b0;
    if (p <= 5'd23) begin
      man0 = 24'(mag << (5'd23 - p));
    end else begin
      // round to nearest even at 24 significant bits
      lsb = 4'(p - 5'd23);
      man0 = 24'(mag >> lsb);
      rem = mag & ((32'd1 << lsb) - 32'd1);
      half = 32'd1 << (lsb - 4'd1);
      inc = (rem > half) || ((rem == half) && man0[0]);
    end
    man25 = {1'b0, man0} + 25'(inc);
    if (man25[24]) begin
      man = man25[24:1];
      pe = 6'(p) + 6'd1;
    end else begin
      man = man25[23:0];
      pe = 6'(p);
    end
    expo = 8'(10'd127 + 10'(pe) - 10'(k));

    if (src_fmt_i == asfc_pkg::FMT_F32) begin
      fbits_o = raw_i;
    end else if (!is_int || mag == '0) begin
      fbits_o = '0;
    end else begin
      fbits_o = {w[32], expo, man[22:0]};
    end
  end

endmodule

// File: rtl/asfc_scale.sv
module asfc_scale (
  input  asfc_pkg::fmt_e dst_fmt_i,
  input  logic [31:0]    fbits_i,
  output asfc_pkg::scl_t scl_o
);

  logic                      sgn;
  logic [7:0]                e;
  logic [22:0]               m;
  logic [4:0]                k;
  logic signed [9:0]         q;
  logic [5:0]                sh;
  logic [asfc_pkg::MagW-1:0] x;
  logic [asfc_pkg::MagW-1:0] lim;
  logic [asfc_pkg::MagW-1:0] hlf;

  always_comb begin
    sgn = fbits_i[31];
    e = fbits_i[30:23];
    m = fbits_i[22:0];
    k = asfc_pkg::fmt_shift(dst_fmt_i);
    q = $signed({2'b00, e}) - 10'sd127 + $signed({5'b0, k});
    sh = 6'(q + 10'sd2);
    x = asfc_pkg::MagW'({1'b1, m}) << sh;
    lim = asfc_pkg::MagW'((64'd1 << k) - 64'd1) << asfc_pkg::FracW;
    hlf = asfc_pkg::MagW'(1) << (asfc_pkg::FracW - 1);

    scl_o.kind = asfc_pkg::K_ZERO;
    scl_o.neg = sgn;
    scl_o.mag = '0;
    if (dst_fmt_i == asfc_pkg::FMT_F32) begin
      scl_o.mag = asfc_pkg::MagW'(fbits_i);
    end else if ((e == 8'hff && m != '0) || e == 8'h00) begin
      // NaN, zero and subnormals all land on zero
      scl_o.kind = asfc_pkg::K_ZERO;
    end else if (q >= $signed({5'b0, k})) begin
      scl_o.kind = sgn ? asfc_pkg::K_MIN : asfc_pkg::K_MAX;
    end else if (q < -10'sd2) begin
      scl_o.kind = asfc_pkg::K_ZERO;
    end else if (!sgn) begin
      if (k != 5'd31 && x >= lim) begin
        scl_o.kind = asfc_pkg::K_MAX;
      end else begin
        scl_o.kind = asfc_pkg::K_ROUND;
        scl_o.mag = x + hlf;
      end
    end else if (x < hlf) begin
      scl_o.kind = asfc_pkg::K_ZERO;
    end else begin
      // n + 0.5 is not positive: carry magnitude |n| - 0.5
      scl_o.kind = asfc_pkg::K_ROUND;
      scl_o.mag = x - hlf;
    end
  end

endmodule

// File: rtl/asfc_round.sv
module asfc_round (
  input  asfc_pkg::fmt_e dst_fmt_i,
  input  asfc_pkg::scl_t scl_i,
  output logic [31:0]    sample_o
);

  logic [5:0]                p;
  logic [5:0]                lsb;
  logic [asfc_pkg::MagW-1:0] mask;
  logic [asfc_pkg::MagW-1:0] rem;
  logic [asfc_pkg::MagW-1:0] half;
  logic                      inc;
  logic [asfc_pkg::MagW:0]   rnd;
  logic [32:0]               ival;
  logic [32:0]               v;
  logic [4:0]                k;

  always_comb begin
    p = '0;
    for (int i = 0; i < asfc_pkg::MagW; i++) begin
      if (scl_i.mag[i]) p = 6'(i);
    end
    lsb = (p > 6'd23) ? p - 6'd23 : 6'd0;
    mask = (asfc_pkg::MagW'(1) << lsb) - asfc_pkg::MagW'(1);
    rem = scl_i.mag & mask;
    half = (lsb == '0) ? '0 : asfc_pkg::MagW'(1) << (lsb - 6'd1);
    inc = (lsb != '0) && ((rem > half) || ((rem == half) && scl_i.mag[lsb]));
    rnd = {1'b0, scl_i.mag & ~mask} + (inc ? (asfc_pkg::MagW + 1)'(1) << lsb : '0);
    ival = rnd[asfc_pkg::MagW:asfc_pkg::FracW];
    k = asfc_pkg::fmt_shift(dst_fmt_i);

    case (scl_i.kind)
      asfc_pkg::K_MIN:   v = ~(33'd1 << k) + 33'd1;
      asfc_pkg::K_MAX:   v = (33'd1 << k) - 33'd1;
      asfc_pkg::K_ROUND: v = scl_i.neg ? ~ival + 33'd1 : ival;
      default:           v = '0;
    endcase

    case (dst_fmt_i)
      asfc_pkg::FMT_U8:  sample_o = {24'b0, v[7] ^ 1'b1, v[6:0]};
      asfc_pkg::FMT_S16: sample_o = {16'b0, v[15:0]};
      asfc_pkg::FMT_S24: sample_o = {8'b0, v[23:0]};
      asfc_pkg::FMT_S32: sample_o = v[31:0];
      asfc_pkg::FMT_F32: sample_o = scl_i.mag[31:0];
      default:           sample_o = '0;
    endcase
  end

endmodule
